// ===== hw/rtl/fps_pkg.sv =====
// shared constants, codes and prolog signature table for the function prolog scanner
`default_nettype none

package fps_pkg;

    localparam int SECTION_BYTES = 4096;
    localparam int ADDR_W        = $clog2(SECTION_BYTES);
    localparam int LEN_W         = $clog2(SECTION_BYTES + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int WIN_BYTES   = 7;

    typedef enum logic [1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_DROPPED = 2'd1,
        STATUS_FOUND   = 2'd2,
        STATUS_DONE    = 2'd3
    } status_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_FIND = 1'b1
    } req_t;

    typedef enum logic {
        CFG_WIDE_MODE      = 1'b0,
        CFG_SECTION_OFFSET = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    localparam logic [7:0] HOTPATCH_HI = 8'h8B;
    localparam logic [7:0] HOTPATCH_LO = 8'hFF;
    localparam logic [2:0] LAST_NARROW = 3'd1;
    localparam logic [2:0] LAST_WIDE   = 3'd5;

    function automatic logic [2:0] sig_len(input logic [2:0] k);
        logic [2:0] n;
        unique case (k)
            3'd0, 3'd1, 3'd5: n = 3'd3;
            3'd2:             n = 3'd4;
            3'd3, 3'd4:       n = 3'd5;
            default:          n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] sig_byte(input logic [2:0] k, input logic [2:0] j);
        logic [7:0] b;
        b = 8'h00;
        unique case (k)
            3'd0:
            begin
                unique case (j)
                    3'd0:    b = 8'h55;
                    3'd1:    b = 8'h8B;
                    3'd2:    b = 8'hEC;
                    default: b = 8'h00;
                endcase
            end
            3'd1:
            begin
                unique case (j)
                    3'd0:    b = 8'h55;
                    3'd1:    b = 8'h89;
                    3'd2:    b = 8'hE5;
                    default: b = 8'h00;
                endcase
            end
            3'd2:
            begin
                unique case (j)
                    3'd0:    b = 8'h55;
                    3'd1:    b = 8'h48;
                    3'd2:    b = 8'h8B;
                    3'd3:    b = 8'hEC;
                    default: b = 8'h00;
                endcase
            end
            3'd3:
            begin
                unique case (j)
                    3'd0:    b = 8'h40;
                    3'd1:    b = 8'h53;
                    3'd2:    b = 8'h48;
                    3'd3:    b = 8'h83;
                    3'd4:    b = 8'hEC;
                    default: b = 8'h00;
                endcase
            end
            3'd4:
            begin
                unique case (j)
                    3'd0:    b = 8'h40;
                    3'd1:    b = 8'h55;
                    3'd2:    b = 8'h48;
                    3'd3:    b = 8'h83;
                    3'd4:    b = 8'hEC;
                    default: b = 8'h00;
                endcase
            end
            3'd5:
            begin
                unique case (j)
                    3'd0:    b = 8'h48;
                    3'd1:    b = 8'h83;
                    3'd2:    b = 8'hEC;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/function_prolog_scanner.sv =====
// function prolog scanner top level: byte store, scan sequencer and result register
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: data_byte; tuser: req_type, first_byte
// m_*       out  m_tvalid/m_tready  tdata: match fields; tuser: status
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// loads stream at one per cycle while results drain
// a find answers in the following cycle when finished or nothing is left, else it walks the
// store through its single read port, once for each signature tried
// reset clears length, position, finished flag, result valid and config registers; store contents stay undefined
// the input stalls while a find is scanning or while a result waits untaken
`default_nettype none

module function_prolog_scanner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fps_pkg::IN_TDATA_W-1:0]     s_tdata,  // data_byte
    input  logic [fps_pkg::IN_TUSER_W-1:0]     s_tuser,  // req_type, first_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // match_offset, match_length, pattern_index, hotpatch_seen, zero pad
    output logic [fps_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [fps_pkg::OUT_TUSER_W-1:0]    m_tuser,  // status
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import fps_pkg::*;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              fin_reg, fin_next;
    logic [LEN_W-1:0]  ia_reg, ia_next;
    logic [ADDR_W-1:0] da_reg, da_next;
    logic              vq_reg, vq_next;
    logic [2:0]        k_reg, k_next;
    logic [7:0]        win_reg [WIN_BYTES-1], win_next [WIN_BYTES-1];

    logic              wide_reg;
    logic [31:0]       sfo_reg;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [31:0]       out_offset_reg, out_offset_next;
    logic [2:0]        out_len_reg, out_len_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic              out_hp_reg, out_hp_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic              s_accept;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  rstart;
    logic [2:0]        last_k;
    logic [2:0]        sig_n;
    logic [7:0]        w [WIN_BYTES];
    logic              bytes_ok;
    logic              pos_ok;
    logic              pre_ok;
    logic [LEN_W-1:0]  end_pos;
    logic [LEN_W-1:0]  start_pos;
    logic [LEN_W-1:0]  match_start;
    logic              issuing;

    fps_ram #(
        .WIDTH (8),
        .DEPTH (SECTION_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_hp_reg, out_idx_reg, out_len_reg, out_offset_reg};

    assign eff_len = s_tuser[1] ? '0 : len_reg;
    assign rstart  = (pos_reg >= LEN_W'(2)) ? pos_reg - LEN_W'(2) : '0;
    assign last_k  = wide_reg ? LAST_WIDE : LAST_NARROW;
    assign sig_n   = sig_len(k_reg);
    assign issuing = ia_reg < len_reg;

    // shared compare unit over the byte window, newest byte first
    always_comb
    begin : compare_unit
        logic [2:0] pi;
        w[0] = ram_rdata;
        for (int j = 1; j < WIN_BYTES; j++)
        begin
            w[j] = win_reg[j-1];
        end
        bytes_ok = 1'b1;
        for (int j = 0; j < 5; j++)
        begin
            pi = sig_n - 3'(j) - 3'd1;
            if ((3'(j) < sig_n) && (w[j] != sig_byte(k_reg, pi)))
            begin
                bytes_ok = 1'b0;
            end
        end
        end_pos   = LEN_W'(da_reg) + LEN_W'(1);
        pos_ok    = {1'b0, end_pos} >= ({1'b0, pos_reg} + (LEN_W + 1)'(sig_n));
        start_pos = end_pos - LEN_W'(sig_n);
        pre_ok    = (start_pos >= LEN_W'(2)) && (w[sig_n] == HOTPATCH_LO)
                    && (w[sig_n + 3'd1] == HOTPATCH_HI);
        match_start = pre_ok ? start_pos - LEN_W'(2) : start_pos;
    end

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        fin_next        = fin_reg;
        ia_next         = ia_reg;
        da_next         = da_reg;
        vq_next         = 1'b0;
        k_next          = k_reg;
        win_next        = win_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_len_next    = out_len_reg;
        out_idx_next    = out_idx_reg;
        out_hp_next     = out_hp_reg;
        ram_we          = 1'b0;
        ram_waddr       = eff_len[ADDR_W-1:0];
        ram_wdata       = s_tdata[7:0];
        ram_raddr       = ia_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    out_valid_next  = 1'b1;
                    out_offset_next = '0;
                    out_len_next    = '0;
                    out_idx_next    = '0;
                    out_hp_next     = 1'b0;
                    if (s_tuser[0] == REQ_LOAD)
                    begin
                        if (s_tuser[1])
                        begin
                            pos_next = '0;
                            fin_next = 1'b0;
                        end
                        if (eff_len == LEN_W'(SECTION_BYTES))
                        begin
                            len_next        = eff_len;
                            out_status_next = STATUS_DROPPED;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            len_next        = eff_len + LEN_W'(1);
                            out_status_next = STATUS_STORED;
                        end
                    end
                    else if (fin_reg || (pos_reg >= len_reg))
                    begin
                        fin_next        = 1'b1;
                        out_status_next = STATUS_DONE;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_SCAN;
                        k_next         = '0;
                        ia_next        = rstart;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    ia_next = ia_reg + LEN_W'(1);
                    da_next = ia_reg[ADDR_W-1:0];
                    vq_next = 1'b1;
                end
                if (vq_reg)
                begin
                    win_next[0] = ram_rdata;
                    for (int j = 1; j < WIN_BYTES - 1; j++)
                    begin
                        win_next[j] = win_reg[j-1];
                    end
                end
                if (vq_reg && bytes_ok && pos_ok)
                begin
                    state_next      = ST_IDLE;
                    vq_next         = 1'b0;
                    pos_next        = end_pos;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_FOUND;
                    out_offset_next = sfo_reg + 32'(match_start);
                    out_len_next    = pre_ok ? sig_n + 3'd2 : sig_n;
                    out_idx_next    = k_reg;
                    out_hp_next     = pre_ok;
                end
                else if (!vq_reg && !issuing)
                begin
                    if (k_reg == last_k)
                    begin
                        state_next      = ST_IDLE;
                        fin_next        = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_DONE;
                        out_offset_next = '0;
                        out_len_next    = '0;
                        out_idx_next    = '0;
                        out_hp_next     = 1'b0;
                    end
                    else
                    begin
                        k_next  = k_reg + 3'd1;
                        ia_next = rstart;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            fin_reg       <= 1'b0;
            vq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            wide_reg      <= 1'b0;
            sfo_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            fin_reg       <= fin_next;
            vq_reg        <= vq_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WIDE_MODE:      wide_reg <= cfg_data[0];
                    CFG_SECTION_OFFSET: sfo_reg  <= cfg_data;
                    default:            wide_reg <= wide_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg         <= ia_next;
        da_reg         <= da_next;
        k_reg          <= k_next;
        win_reg        <= win_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_len_reg    <= out_len_next;
        out_idx_reg    <= out_idx_next;
        out_hp_reg     <= out_hp_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fps_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module fps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
